// File: hdl/sem_pkg.sv
// Shared types and constants for the semaphore table.
// Used by the top level; no dependencies.
`timescale 1ns / 1ps

package sem_pkg;

    localparam int NUM_SEM  = 16;
    localparam int NUM_WAIT = 16;

    localparam int SEM_W  = (NUM_SEM > 1) ? $clog2(NUM_SEM) : 1;
    localparam int SEM_CW = $clog2(NUM_SEM + 1);
    localparam int WAIT_W = (NUM_WAIT > 1) ? $clog2(NUM_WAIT) : 1;
    localparam int TOT_W  = $clog2(NUM_WAIT + 1);
    localparam int SLOT_N = NUM_SEM * NUM_WAIT;
    localparam int SLOT_W = (SLOT_N > 1) ? $clog2(SLOT_N) : 1;

    localparam logic [1:0] K_CREATE  = 2'd0;
    localparam logic [1:0] K_DESTROY = 2'd1;
    localparam logic [1:0] K_WAIT    = 2'd2;
    localparam logic [1:0] K_SIGNAL  = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ACQUIRED   = 3'd1;
    localparam logic [2:0] ST_BLOCKED    = 3'd2;
    localparam logic [2:0] ST_INVALID    = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [2:0] ST_TABLE_FULL = 3'd5;
    localparam logic [2:0] ST_QUEUE_FULL = 3'd6;

    typedef struct packed {
        logic [31:0]       key;
        logic [31:0]       count;
        logic [WAIT_W-1:0] head;
        logic [TOT_W-1:0]  total;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// File: hdl/sem_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sem_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

// File: hdl/semaphore_table_with_wait_queues.sv
// Counting semaphore table with per-semaphore waiter rings.
// Sequence: a zero key goes straight to the result; otherwise a table scan, a decide
// step, then where needed a ring scan (wait/signal) or a ring clear (destroy), then the output step.
// Throughput: one command at a time.
// Reset: synchronous; a clearing pass zeroes both memories, with o_ready low until
// it ends. Depends on sem_pkg and sem_ram.
`timescale 1ns / 1ps

module semaphore_table_with_wait_queues (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_sem_key,
    input  logic [31:0] i_init_count,
    input  logic [15:0] i_caller_pid,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic        o_wake_valid,
    output logic [15:0] o_wake_pid
);

    localparam int SEM_W  = sem_pkg::SEM_W;
    localparam int SEM_CW = sem_pkg::SEM_CW;
    localparam int WAIT_W = sem_pkg::WAIT_W;
    localparam int TOT_W  = sem_pkg::TOT_W;
    localparam int SLOT_W = sem_pkg::SLOT_W;

    // Sequencer states
    localparam logic [2:0] S_CLR  = 3'd0;   // post-reset memory clear
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;   // walk the key table
    localparam logic [2:0] S_DEC  = 3'd3;   // act on the scan result
    localparam logic [2:0] S_RING = 3'd4;   // walk the waiter ring
    localparam logic [2:0] S_DCLR = 3'd5;   // destroy: zero the ring
    localparam logic [2:0] S_FIN  = 3'd6;   // hand result to output reg

    function automatic logic [SLOT_W-1:0] slot_addr(input logic [SEM_W-1:0] e,
                                                    input logic [WAIT_W-1:0] p);
        return SLOT_W'(32'(e) * sem_pkg::NUM_WAIT + 32'(p));
    endfunction

    function automatic logic [WAIT_W-1:0] next_pos(input logic [WAIT_W-1:0] p);
        return (32'(p) == sem_pkg::NUM_WAIT - 1) ? '0 : WAIT_W'(32'(p) + 1);
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_kind, n_kind;
    logic [31:0]       r_key, n_key;
    logic [31:0]       r_init, n_init;
    logic [15:0]       r_pid, n_pid;
    logic [SEM_CW-1:0] r_cnt, n_cnt;       // table scan counter
    logic [SEM_CW-1:0] r_used, n_used;
    logic              r_found, n_found;
    logic [SEM_W-1:0]  r_fidx, n_fidx;
    logic              r_free_ok, n_free_ok;
    logic [SEM_W-1:0]  r_free_idx, n_free_idx;
    sem_pkg::t_entry   r_ent, n_ent;       // entry under work
    logic [TOT_W-1:0]  r_rc, n_rc;         // ring step counter
    logic [WAIT_W-1:0] r_pos, n_pos;       // ring read position issued
    logic [WAIT_W-1:0] r_cpos, n_cpos;     // position of data now on the read port
    logic [SLOT_W-1:0] r_clr, n_clr;
    logic [2:0]        r_res_st, n_res_st;
    logic              r_res_wv, n_res_wv;
    logic [15:0]       r_res_wp, n_res_wp;
    logic              r_ovalid, n_ovalid;
    logic [2:0]        r_ost, n_ost;
    logic              r_owv, n_owv;
    logic [15:0]       r_owp, n_owp;

    // Memory ports
    logic                        ent_we;
    logic [SEM_W-1:0]            ent_waddr, ent_raddr;
    sem_pkg::t_entry             ent_wdata, ent_rdata;
    logic [sem_pkg::ENTRY_W-1:0] ent_rbits;
    logic                        slot_we;
    logic [SLOT_W-1:0]           slot_waddr, slot_raddr;
    logic [15:0]                 slot_wdata, slot_rdata;

    assign ent_rdata = sem_pkg::t_entry'(ent_rbits);

    sem_ram #(.DEPTH(sem_pkg::NUM_SEM), .WIDTH(sem_pkg::ENTRY_W)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rbits)
    );

    sem_ram #(.DEPTH(sem_pkg::SLOT_N), .WIDTH(16)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // Input is taken only between commands; the output register lets a
    // new command start while the previous result waits.
    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_status     = r_ost;
    assign o_wake_valid = r_owv;
    assign o_wake_pid   = r_owp;

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_key      = r_key;
        n_init     = r_init;
        n_pid      = r_pid;
        n_cnt      = r_cnt;
        n_used     = r_used;
        n_found    = r_found;
        n_fidx     = r_fidx;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_ent      = r_ent;
        n_rc       = r_rc;
        n_pos      = r_pos;
        n_cpos     = r_cpos;
        n_clr      = r_clr;
        n_res_st   = r_res_st;
        n_res_wv   = r_res_wv;
        n_res_wp   = r_res_wp;
        n_ovalid   = r_ovalid;
        n_ost      = r_ost;
        n_owv      = r_owv;
        n_owp      = r_owp;

        ent_we     = 1'b0;
        ent_waddr  = r_fidx;
        ent_wdata  = r_ent;
        ent_raddr  = r_cnt[SEM_W-1:0];
        slot_we    = 1'b0;
        slot_waddr = slot_addr(r_fidx, r_cpos);
        slot_wdata = 16'd0;
        slot_raddr = slot_addr(r_fidx, r_pos);

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr;
                if (32'(r_clr) < sem_pkg::NUM_SEM) begin
                    ent_we    = 1'b1;
                    ent_waddr = r_clr[SEM_W-1:0];
                    ent_wdata = '0;
                end
                n_clr = r_clr + SLOT_W'(1);
                if (32'(r_clr) == sem_pkg::SLOT_N - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_kind    = i_kind;
                    n_key     = i_sem_key;
                    n_init    = i_init_count;
                    n_pid     = i_caller_pid;
                    n_cnt     = '0;
                    n_found   = 1'b0;
                    n_free_ok = 1'b0;
                    n_res_wv  = 1'b0;
                    n_res_wp  = 16'd0;
                    if (i_sem_key == 32'd0) begin
                        n_res_st = sem_pkg::ST_INVALID;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Read data comes from the registered read port and lags the address.
                if (r_cnt != '0) begin
                    if (!r_found && ent_rdata.key == r_key) begin
                        n_found = 1'b1;
                        n_fidx  = SEM_W'(r_cnt - SEM_CW'(1));
                        n_ent   = ent_rdata;
                    end
                    if (!r_free_ok && ent_rdata.key == 32'd0) begin
                        n_free_ok  = 1'b1;
                        n_free_idx = SEM_W'(r_cnt - SEM_CW'(1));
                    end
                end
                n_cnt = r_cnt + SEM_CW'(1);
                if (32'(r_cnt) == sem_pkg::NUM_SEM) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state  = S_FIN;
                n_res_st = sem_pkg::ST_OK;
                if (r_kind == sem_pkg::K_CREATE) begin
                    if (32'(r_used) >= sem_pkg::NUM_SEM) begin
                        n_res_st = sem_pkg::ST_TABLE_FULL;
                    end else if (r_found) begin
                        n_res_st = sem_pkg::ST_INVALID;
                    end else if (!r_free_ok) begin
                        n_res_st = sem_pkg::ST_TABLE_FULL;
                    end else begin
                        ent_we          = 1'b1;
                        ent_waddr       = r_free_idx;
                        ent_wdata       = '0;
                        ent_wdata.key   = r_key;
                        ent_wdata.count = r_init;
                        n_used          = r_used + SEM_CW'(1);
                    end
                end else if (!r_found) begin
                    n_res_st = sem_pkg::ST_NOT_FOUND;
                end else if (r_kind == sem_pkg::K_DESTROY) begin
                    ent_we    = 1'b1;
                    ent_wdata = '0;
                    if (r_used != '0) begin
                        n_used = r_used - SEM_CW'(1);
                    end
                    n_rc    = '0;
                    n_state = S_DCLR;
                end else if (r_kind == sem_pkg::K_WAIT) begin
                    if (r_ent.count != 32'd0) begin
                        ent_we          = 1'b1;
                        ent_wdata.count = r_ent.count - 32'd1;
                        n_res_st        = sem_pkg::ST_ACQUIRED;
                    end else if (r_pid == 16'd0) begin
                        n_res_st = sem_pkg::ST_INVALID;
                    end else if (32'(r_ent.total) >= sem_pkg::NUM_WAIT) begin
                        n_res_st = sem_pkg::ST_QUEUE_FULL;
                    end else begin
                        n_rc    = '0;
                        n_pos   = r_ent.head;
                        n_state = S_RING;
                    end
                end else begin
                    if (r_ent.total != '0) begin
                        n_rc    = '0;
                        n_pos   = r_ent.head;
                        n_state = S_RING;
                    end else begin
                        ent_we          = 1'b1;
                        ent_wdata.count = sat_inc(r_ent.count);
                    end
                end
            end
            S_RING: begin
                n_pos  = next_pos(r_pos);
                n_cpos = r_pos;
                n_rc   = r_rc + TOT_W'(1);
                if (r_rc != '0) begin
                    if (r_kind == sem_pkg::K_WAIT) begin
                        if (slot_rdata == 16'd0) begin
                            slot_we         = 1'b1;
                            slot_wdata      = r_pid;
                            ent_we          = 1'b1;
                            ent_wdata.total = r_ent.total + TOT_W'(1);
                            n_res_st        = sem_pkg::ST_BLOCKED;
                            n_state         = S_FIN;
                        end else if (32'(r_rc) == sem_pkg::NUM_WAIT) begin
                            n_res_st = sem_pkg::ST_QUEUE_FULL;
                            n_state  = S_FIN;
                        end
                    end else begin
                        if (slot_rdata != 16'd0) begin
                            slot_we         = 1'b1;
                            ent_we          = 1'b1;
                            ent_wdata.total = r_ent.total - TOT_W'(1);
                            ent_wdata.head  = next_pos(r_cpos);
                            n_res_wv        = 1'b1;
                            n_res_wp        = slot_rdata;
                            n_state         = S_FIN;
                        end else if (32'(r_rc) == sem_pkg::NUM_WAIT) begin
                            // Full lap without a waiter: head comes back to itself.
                            ent_we          = 1'b1;
                            ent_wdata.count = sat_inc(r_ent.count);
                            n_state         = S_FIN;
                        end
                    end
                end
            end
            S_DCLR: begin
                slot_we    = 1'b1;
                slot_waddr = slot_addr(r_fidx, r_rc[WAIT_W-1:0]);
                n_rc       = r_rc + TOT_W'(1);
                if (32'(r_rc) == sem_pkg::NUM_WAIT - 1) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_res_st;
                    n_owv    = r_res_wv;
                    n_owp    = r_res_wp;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_used   <= n_used;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_key      <= n_key;
        r_init     <= n_init;
        r_pid      <= n_pid;
        r_cnt      <= n_cnt;
        r_found    <= n_found;
        r_fidx     <= n_fidx;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_ent      <= n_ent;
        r_rc       <= n_rc;
        r_pos      <= n_pos;
        r_cpos     <= n_cpos;
        r_res_st   <= n_res_st;
        r_res_wv   <= n_res_wv;
        r_res_wp   <= n_res_wp;
        r_ost      <= n_ost;
        r_owv      <= n_owv;
        r_owp      <= n_owp;
    end

    // A wake only comes with an ok status.
    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_wake_valid) |-> (o_status == sem_pkg::ST_OK))
        else $error("wake reported with non-ok status");

    // No wake means a zero pid.
    a_wake_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_wake_valid) |-> (o_wake_pid == 16'd0))
        else $error("wake pid set without wake");

    // Occupancy never exceeds the table size.
    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= sem_pkg::NUM_SEM)
        else $error("used entry count overflow");

    // An accepted command always leaves idle on the next cycle.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_SCAN || r_state == S_FIN))
        else $error("accepted command did not start");

endmodule

// File: dv/testbench.sv
// Self-checking bench for semaphore_table_with_wait_queues: directed, overflow and random tests.
// Results are checked against an in-bench model of the semaphore table. Depends on sem_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_SEM  = sem_pkg::NUM_SEM;
    localparam int NUM_WAIT = sem_pkg::NUM_WAIT;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [31:0] init;
        logic [15:0] pid;
        bit          typed;   // expected status typed into the table
        logic [2:0]  status;
    } t_cmd;

    typedef struct {
        logic [2:0]  status;
        logic        wvalid;
        logic [15:0] wpid;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind = '0;
    logic [31:0] i_sem_key = '0;
    logic [31:0] i_init_count = '0;
    logic [15:0] i_caller_pid = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic        o_wake_valid;
    logic [15:0] o_wake_pid;

    always #5 i_clk = ~i_clk;

    semaphore_table_with_wait_queues uut (.*);

    // model state of the table
    logic [31:0] m_key   [NUM_SEM];
    logic [31:0] m_count [NUM_SEM];
    logic [15:0] m_slot  [NUM_SEM][NUM_WAIT];
    int          m_head  [NUM_SEM];
    int          m_total [NUM_SEM];
    int          m_used;

    t_res expected_q[$];
    int   errors = 0;
    int   cycles = 0;
    logic [31:0] key_pool[8];

    function automatic t_res semaphore_step(t_cmd c);
        t_res r;
        int e, p, freep;
        bit dup;
        r = '{sem_pkg::ST_OK, 1'b0, 16'd0};
        e = -1;
        freep = -1;
        dup = 0;
        if (c.key == 0) begin
            r.status = sem_pkg::ST_INVALID;
        end else if (c.kind == sem_pkg::K_CREATE) begin
            if (m_used >= NUM_SEM) begin
                r.status = sem_pkg::ST_TABLE_FULL;
            end else begin
                for (int i = 0; i < NUM_SEM; i++) begin
                    if (freep < 0 && m_key[i] == 0) freep = i;
                    if (m_key[i] == c.key) dup = 1;
                end
                if (dup) r.status = sem_pkg::ST_INVALID;
                else if (freep < 0) r.status = sem_pkg::ST_TABLE_FULL;
                else begin
                    m_key[freep] = c.key;
                    m_count[freep] = c.init;
                    m_used++;
                end
            end
        end else begin
            for (int i = NUM_SEM - 1; i >= 0; i--)
                if (m_key[i] == c.key) e = i;
            if (e < 0) begin
                r.status = sem_pkg::ST_NOT_FOUND;
            end else if (c.kind == sem_pkg::K_DESTROY) begin
                m_key[e] = 0;
                m_count[e] = 0;
                m_head[e] = 0;
                m_total[e] = 0;
                for (int i = 0; i < NUM_WAIT; i++) m_slot[e][i] = 0;
                if (m_used > 0) m_used--;
            end else if (c.kind == sem_pkg::K_WAIT) begin
                if (m_count[e] > 0) begin
                    m_count[e]--;
                    r.status = sem_pkg::ST_ACQUIRED;
                end else if (c.pid == 0) begin
                    r.status = sem_pkg::ST_INVALID;
                end else begin
                    r.status = sem_pkg::ST_QUEUE_FULL;
                    if (m_total[e] < NUM_WAIT) begin
                        p = m_head[e];
                        for (int i = 0; i < NUM_WAIT; i++) begin
                            if (m_slot[e][p] == 0) begin
                                m_slot[e][p] = c.pid;
                                m_total[e]++;
                                r.status = sem_pkg::ST_BLOCKED;
                                break;
                            end
                            p = (p + 1) % NUM_WAIT;
                        end
                    end
                end
            end else begin
                if (m_total[e] > 0) begin
                    p = m_head[e];
                    for (int i = 0; i < NUM_WAIT; i++) begin
                        if (m_slot[e][p] != 0) begin
                            r.wvalid = 1'b1;
                            r.wpid = m_slot[e][p];
                            m_slot[e][p] = 0;
                            m_total[e]--;
                            p = (p + 1) % NUM_WAIT;
                            break;
                        end
                        p = (p + 1) % NUM_WAIT;
                    end
                    m_head[e] = p;
                end
                if (!r.wvalid && m_count[e] != 32'hFFFF_FFFF) m_count[e]++;
            end
        end
        return r;
    endfunction

    // one transfer on the command side, with a random gap first;
    // valid stays up after the transfer when the next one follows at once
    task automatic send_cmd(t_cmd c);
        t_res r;
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_kind <= c.kind;
        i_sem_key <= c.key;
        i_init_count <= c.init;
        i_caller_pid <= c.pid;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        r = semaphore_step(c);
        if (c.typed && r.status != c.status) begin
            errors++;
            if (errors <= 10)
                $display("table row status %0d, model says %0d", c.status, r.status);
        end
        expected_q.push_back(r);
    endtask

    // result side: random stalls, compare against oldest expectation
    initial begin
        int stall;
        t_res x;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected transfer status=%0d", o_status);
            end else begin
                x = expected_q.pop_front();
                if (o_status !== x.status || o_wake_valid !== x.wvalid
                        || o_wake_pid !== x.wpid) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %0d/%0d/%0h got %0d/%0d/%0h",
                                 x.status, x.wvalid, x.wpid,
                                 o_status, o_wake_valid, o_wake_pid);
                end
            end
        end
    end

    // watchdog: a bound above the reset clearing pass and all items with stalls, many times over
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("[semaphore_table_with_wait_queues] ERROR");
            $finish;
        end
    end

    function automatic t_cmd mk(logic [1:0] k, logic [31:0] key, logic [31:0] init,
                                logic [15:0] pid, bit typed, logic [2:0] st);
        t_cmd c;
        c = '{k, key, init, pid, typed, st};
        return c;
    endfunction

    initial begin
        t_cmd dir[$];
        t_cmd c;
        int n;
        for (int i = 0; i < NUM_SEM; i++) begin
            m_key[i] = 0; m_count[i] = 0; m_head[i] = 0; m_total[i] = 0;
            for (int j = 0; j < NUM_WAIT; j++) m_slot[i][j] = 0;
        end
        m_used = 0;
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom | 32'h1;
        key_pool[0] = 32'hFFFF_FFFF;
        key_pool[1] = 32'h1;

        // directed table
        dir.push_back(mk(sem_pkg::K_CREATE, 0, 5, 1, 1, sem_pkg::ST_INVALID));
        dir.push_back(mk(sem_pkg::K_SIGNAL, 32'h55, 0, 1, 1, sem_pkg::ST_NOT_FOUND));
        dir.push_back(mk(sem_pkg::K_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1, 1,
                         sem_pkg::ST_OK));
        dir.push_back(mk(sem_pkg::K_CREATE, 32'hFFFF_FFFF, 0, 1, 1, sem_pkg::ST_INVALID));
        dir.push_back(mk(sem_pkg::K_SIGNAL, 32'hFFFF_FFFF, 0, 0, 1, sem_pkg::ST_OK));
        dir.push_back(mk(sem_pkg::K_SIGNAL, 32'hFFFF_FFFF, 0, 0, 1,
                         sem_pkg::ST_OK));                            // saturates
        dir.push_back(mk(sem_pkg::K_WAIT, 32'hFFFF_FFFF, 0, 0, 1, sem_pkg::ST_ACQUIRED));
        dir.push_back(mk(sem_pkg::K_CREATE, 32'h1, 0, 1, 1, sem_pkg::ST_OK));
        dir.push_back(mk(sem_pkg::K_WAIT, 32'h1, 0, 0, 1,
                         sem_pkg::ST_INVALID));                       // pid zero, no count
        dir.push_back(mk(sem_pkg::K_WAIT, 32'h1, 0, 16'hFFFF, 1, sem_pkg::ST_BLOCKED));
        dir.push_back(mk(sem_pkg::K_WAIT, 32'h1, 32'hFFFF_FFFF, 16'h0001, 1,
                         sem_pkg::ST_BLOCKED));
        dir.push_back(mk(sem_pkg::K_SIGNAL, 32'h1, 0, 0, 0, 0));
        dir.push_back(mk(sem_pkg::K_WAIT, 32'h1, 0, 16'h1234, 0, 0));
        dir.push_back(mk(sem_pkg::K_SIGNAL, 32'h1, 0, 0, 0, 0));
        dir.push_back(mk(sem_pkg::K_DESTROY, 32'h1, 0, 0, 1,
                         sem_pkg::ST_OK));                            // drops waiter
        dir.push_back(mk(sem_pkg::K_DESTROY, 32'h1, 0, 0, 1, sem_pkg::ST_NOT_FOUND));
        dir.push_back(mk(sem_pkg::K_WAIT, 0, 0, 5, 1, sem_pkg::ST_INVALID));
        dir.push_back(mk(sem_pkg::K_DESTROY, 0, 0, 5, 1, sem_pkg::ST_INVALID));
        dir.push_back(mk(sem_pkg::K_WAIT, 32'h77, 0, 5, 1, sem_pkg::ST_NOT_FOUND));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir[i]) send_cmd(dir[i]);

        // fill the table and one ring, then overflow both
        for (int i = 0; i < NUM_SEM; i++)
            send_cmd(mk(sem_pkg::K_CREATE, 32'h100 + i, 0, 0, 0, 0));
        send_cmd(mk(sem_pkg::K_CREATE, 32'h100, 0, 0, 1,
                    sem_pkg::ST_TABLE_FULL));                         // dup on full table
        send_cmd(mk(sem_pkg::K_CREATE, 32'h999, 0, 0, 1, sem_pkg::ST_TABLE_FULL));
        for (int i = 0; i < NUM_WAIT; i++)
            send_cmd(mk(sem_pkg::K_WAIT, 32'h100, 0, $urandom_range(1, 65535), 0, 0));
        send_cmd(mk(sem_pkg::K_WAIT, 32'h100, 0, 16'h4242, 1, sem_pkg::ST_QUEUE_FULL));
        for (int i = 0; i < 5; i++) send_cmd(mk(sem_pkg::K_SIGNAL, 32'h100, 0, 0, 0, 0));
        for (int i = 0; i < 3; i++)
            send_cmd(mk(sem_pkg::K_WAIT, 32'h100, 0, $urandom_range(1, 65535), 0, 0));

        // hold off until everything outstanding has drained
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);

        // destroy the keys made above; the key FFFF_FFFF stays in the table
        for (int i = 0; i < NUM_SEM; i++)
            send_cmd(mk(sem_pkg::K_DESTROY, 32'h100 + i, 0, 0, 0, 0));

        // random traffic, mostly on a small key pool so semaphores live and queue
        n = 0;
        while (n < 1400) begin
            c.typed = 0;
            c.status = 0;
            c.kind = $urandom_range(0, 3);
            if ($urandom_range(0, 9) < 2 && c.kind == sem_pkg::K_CREATE)
                c.kind = sem_pkg::K_WAIT;
            case ($urandom_range(0, 19))
                0:       c.key = 0;
                1:       c.key = $urandom;
                default: c.key = key_pool[$urandom_range(0, 7)];
            endcase
            c.init = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0) c.init = 32'hFFFF_FFFF;
            c.pid = ($urandom_range(0, 29) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
            send_cmd(c);
            n++;
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("[semaphore_table_with_wait_queues] OK");
        end else begin
            $display("[semaphore_table_with_wait_queues] ERROR");
        end
        $finish;
    end
endmodule

// File: filelist.f
hdl/sem_pkg.sv
hdl/sem_ram.sv
hdl/semaphore_table_with_wait_queues.sv
dv/testbench.sv
